// ----- src/four_level_page_table_walker_defines.svh -----
// assertion macros for the four level page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PTW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptw check failed");

// next-cycle implication, checked outside reset
`define PTW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptw check failed");

`endif

// ----- src/ptw_pkg.sv -----
// shared types, constants and helpers for the page table walker
package ptw_pkg;

   localparam int PHYS_ADDR_BITS = 47;
   localparam int ADDR_W         = 48;
   localparam int DATA_W         = 64;
   localparam int UC_BIT_POS     = 4;
   localparam int RSP_DEPTH      = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W      = RSP_PTR_W + 1;

   localparam logic [DATA_W-1:0] FRAME_MASK =
      ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF;

   typedef enum logic [2:0] {
      OP_TR4K   = 3'd0,
      OP_TR2M   = 3'd1,
      OP_SET_UC = 3'd2,
      OP_SET_C  = 3'd3,
      OP_RESP   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_TR4K   = 2'd0,
      KIND_TR2M   = 2'd1,
      KIND_SET_UC = 2'd2,
      KIND_SET_C  = 2'd3
   } op_kind_type;

   typedef enum logic [1:0] {
      RSP_READ   = 2'd0,
      RSP_WRITE  = 2'd1,
      RSP_DONE   = 2'd2,
      RSP_REJECT = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic              busy;
      logic [1:0]        level;
      op_kind_type       op_kind;
      logic [ADDR_W-1:0] saved_va;
      logic [ADDR_W-1:0] pending;
   } walk_state_type;

   typedef struct packed {
      rsp_kind_type      kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp0;
      rsp_type    rsp1;
   } step_out_type;

   // table base plus 8 times the 9-bit index of this level
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [ADDR_W-1:0] va,
                                                    input logic [1:0]        level);
      logic [8:0] idx;
      unique case (level)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return base + {{(ADDR_W-12){1'b0}}, idx, 3'b000};
   endfunction

endpackage

// ----- src/ptw_step.sv -----
// next walk state and results for one transaction
module ptw_step (
   input  ptw_pkg::walk_state_type  cur_state,
   input  logic [63:0]              root_table_address,
   input  logic [2:0]               opcode,
   input  logic [63:0]              virtual_address,
   input  logic [63:0]              read_data,
   output ptw_pkg::walk_state_type  nxt_state,
   output ptw_pkg::step_out_type    step_out
);
   import ptw_pkg::*;

   logic [DATA_W-1:0] frame;
   logic [DATA_W-1:0] root_base;
   logic [ADDR_W-1:0] rd_addr;
   logic [1:0]        final_level;
   logic [1:0]        level_up;
   logic              is_req;

   assign frame       = read_data & FRAME_MASK;
   assign root_base   = root_table_address & FRAME_MASK;
   assign final_level = (cur_state.op_kind == KIND_TR2M) ? 2'd2 : 2'd3;
   assign level_up    = cur_state.level + 2'd1;
   assign is_req      = (opcode == OP_TR4K) || (opcode == OP_TR2M) ||
                        (opcode == OP_SET_UC) || (opcode == OP_SET_C);

   always_comb begin
      nxt_state = cur_state;
      step_out  = '0;
      rd_addr   = '0;
      priority if (is_req && cur_state.busy) begin
         step_out.count     = 2'd1;
         step_out.rsp0.kind = RSP_REJECT;
         step_out.rsp0.last = 1'b1;
      end else if (is_req) begin
         rd_addr             = entry_addr(root_base[ADDR_W-1:0], virtual_address[ADDR_W-1:0],
                                          2'd0);
         nxt_state.busy      = 1'b1;
         nxt_state.level     = 2'd0;
         nxt_state.op_kind   = op_kind_type'(opcode[1:0]);
         nxt_state.saved_va  = virtual_address[ADDR_W-1:0];
         nxt_state.pending   = rd_addr;
         step_out.count      = 2'd1;
         step_out.rsp0.kind  = RSP_READ;
         step_out.rsp0.address = rd_addr;
         step_out.rsp0.last  = 1'b1;
      end else if (opcode == OP_RESP && cur_state.busy) begin
         if (cur_state.level < final_level) begin
            // next level down
            rd_addr               = entry_addr(frame[ADDR_W-1:0], cur_state.saved_va,
                                               level_up);
            nxt_state.level       = level_up;
            nxt_state.pending     = rd_addr;
            step_out.count        = 2'd1;
            step_out.rsp0.kind    = RSP_READ;
            step_out.rsp0.address = rd_addr;
            step_out.rsp0.last    = 1'b1;
         end else begin
            nxt_state.busy  = 1'b0;
            nxt_state.level = 2'd0;
            unique case (cur_state.op_kind)
               KIND_TR4K: begin
                  step_out.count        = 2'd1;
                  step_out.rsp0.kind    = RSP_DONE;
                  step_out.rsp0.address = frame[ADDR_W-1:0] +
                                          {{(ADDR_W-12){1'b0}}, cur_state.saved_va[11:0]};
                  step_out.rsp0.last    = 1'b1;
               end
               KIND_TR2M: begin
                  step_out.count        = 2'd1;
                  step_out.rsp0.kind    = RSP_DONE;
                  step_out.rsp0.address = frame[ADDR_W-1:0] +
                                          {{(ADDR_W-21){1'b0}}, cur_state.saved_va[20:0]};
                  step_out.rsp0.last    = 1'b1;
               end
               KIND_SET_UC, KIND_SET_C: begin
                  step_out.count           = 2'd2;
                  step_out.rsp0.kind       = RSP_WRITE;
                  step_out.rsp0.address    = cur_state.pending;
                  step_out.rsp0.write_data = read_data;
                  step_out.rsp0.write_data[UC_BIT_POS] = (cur_state.op_kind == KIND_SET_UC);
                  step_out.rsp0.last       = 1'b0;
                  step_out.rsp1.kind       = RSP_DONE;
                  step_out.rsp1.address    = frame[ADDR_W-1:0];
                  step_out.rsp1.last       = 1'b1;
               end
               default: begin
                  step_out.count = 2'd0;
               end
            endcase
         end
      end else begin
         nxt_state = cur_state;
      end
   end

endmodule

// ----- src/four_level_page_table_walker.sv -----
// four level page table walker: walk state, result queue and ports
//
// channel  direction  handshake              carries
// req_     in         req_valid / req_ready  opcode, virtual address, read data
// rsp_     out        rsp_valid / rsp_ready  result kind, address, write data, last
// csr_     in         csr_write_enable       root table address
//
// one request or memory response is taken per cycle with req_ready; its results
// enter a four entry result queue at the same edge and leave one per cycle with
// rsp_ready; reset is synchronous and clears walk state, root register and queue
// req_ready drops only when the queue has fewer than two free slots, so a
// stalled rsp_ prevents overflow; the queue output decouples the two sides
module four_level_page_table_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_virtual_address,
   input  logic [63:0] req_read_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [47:0] rsp_address,
   output logic [63:0] rsp_write_data,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);
   import ptw_pkg::*;

   `include "four_level_page_table_walker_defines.svh"

   // walk state and root pointer
   walk_state_type walk_ff;
   walk_state_type walk_in;
   logic [63:0]    root_ff;

   // result queue
   rsp_type              fifo_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff;
   logic [RSP_CNT_W-1:0] count_in;

   step_out_type step_out;
   logic         req_fire;
   logic         rsp_fire;
   logic [RSP_CNT_W-1:0] push_n;

   ptw_step u_step (
      .cur_state          (walk_ff),
      .root_table_address (root_ff),
      .opcode             (req_opcode),
      .virtual_address    (req_virtual_address),
      .read_data          (req_read_data),
      .nxt_state          (walk_in),
      .step_out           (step_out)
   );

   // a transaction can bring up to two results, so keep two slots free
   assign req_ready = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign push_n    = req_fire ? RSP_CNT_W'(step_out.count) : '0;
   assign count_in  = count_ff + push_n - RSP_CNT_W'(rsp_fire);

   // head of the queue drives the result ports
   assign rsp_result_kind = fifo_mem[rd_ptr_ff].kind;
   assign rsp_address     = fifo_mem[rd_ptr_ff].address;
   assign rsp_write_data  = fifo_mem[rd_ptr_ff].write_data;
   assign rsp_last        = fifo_mem[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff   <= '0;
         root_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            root_ff <= csr_write_data;
         end
         if (req_fire) begin
            walk_ff <= walk_in;
         end
         wr_ptr_ff <= wr_ptr_ff + push_n[RSP_PTR_W-1:0];
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && step_out.count != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= step_out.rsp0;
      end
      if (req_fire && step_out.count == 2'd2) begin
         fifo_mem[wr_ptr_ff + RSP_PTR_W'(1)] <= step_out.rsp1;
      end
   end

   // queue never holds more than its depth
   `PTW_ASSERT_NOW(a_queue_bound, 1'b1, count_ff <= RSP_CNT_W'(RSP_DEPTH))
   // an idle walker always sits at the top level
   `PTW_ASSERT_NOW(a_idle_level, !walk_ff.busy, walk_ff.level == 2'd0)
   // a request taken while idle starts a walk
   `PTW_ASSERT_NEXT(a_walk_start,
      req_fire && !walk_ff.busy && (req_opcode == OP_TR4K || req_opcode == OP_TR2M ||
      req_opcode == OP_SET_UC || req_opcode == OP_SET_C), walk_ff.busy)

endmodule
